[hw/rtl/bas_pkg.sv]
// Shared types and constants for the button auto-repeat scanner.
package bas_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int SETTING_W  = 16;
	localparam int STAMP_W    = 32;

	localparam logic [SETTING_W-1:0] DELAY_RESET    = 16'd1000;
	localparam logic [SETTING_W-1:0] INTERVAL_RESET = 16'd150;

	typedef enum logic [0:0] {
		FUNC_POLL   = 1'b0,
		FUNC_INJECT = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		REG_DELAY    = 1'b0,
		REG_INTERVAL = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

endpackage

[hw/rtl/bas_if.sv]
// Valid/ready channel interfaces for poll/inject commands and emitted events.
interface bas_cmd_if #(
	parameter int BUTTON_COUNT = 6,
	parameter int EVENT_W      = 3
);
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [31:0]               now_ms;
	logic [BUTTON_COUNT-1:0]   buttons_low;
	logic [BUTTON_COUNT-1:0]   buttons_confirm;
	logic [EVENT_W-1:0]        event_code;

	modport source (output valid, func, now_ms, buttons_low, buttons_confirm, event_code,
		input ready);
	modport sink (input valid, func, now_ms, buttons_low, buttons_confirm, event_code,
		output ready);
endinterface

interface bas_evt_if #(
	parameter int EVENT_W = 3
);
	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic               dropped;

	modport source (output valid, event_res, dropped, input ready);
	modport sink (input valid, event_res, dropped, output ready);
endinterface

[hw/rtl/bas_inject_ring.sv]
// Ring buffer of injected events with a registered head read.
module bas_inject_ring #(
	parameter int QUEUE_SLOTS = 8,
	parameter int EVENT_W     = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bas_pkg::ring_ctrl_t ctrl,
	input  logic [EVENT_W-1:0]  push_data,
	output bas_pkg::ring_stat_t stat,
	output logic [EVENT_W-1:0]  head_data
);

	localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

	logic [EVENT_W-1:0] mem [QUEUE_SLOTS];
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [PTR_W-1:0]   head_inc, tail_inc, head_d;
	logic [EVENT_W-1:0] head_data_q;

	assign head_inc = (head_q == LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + PTR_W'(1);
	assign head_d   = ctrl.pop ? head_inc : head_q;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (tail_inc == head_q);
	assign head_data  = head_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q <= head_inc;
			end
			if (ctrl.push) begin
				tail_q <= tail_inc;
			end
		end
	end

	// write-through keeps the head word current when pushing into an empty ring
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= push_data;
		end
		if (ctrl.push && (tail_q == head_d)) begin
			head_data_q <= push_data;
		end else begin
			head_data_q <= mem[head_d];
		end
	end

endmodule

[hw/rtl/button_autorepeat_scanner.sv]
// Top level: button scanner with auto-repeat, injected event ring and APB settings.
//
//  channel  dir  handshake        payload
//  cmd      in   valid/ready      func, now_ms, buttons_low, buttons_confirm, event_code
//  evt      out  valid/ready      event_res, dropped
//  apb      in   psel/penable     paddr, pwdata -> prdata, pready tied high
//
// One item per cycle while the result is not stalled: an input register feeds the
// scan/compare logic into the result register, and the result register offers the result.
// A stalled result holds the result register; one more item waits in the
// input register before cmd.ready drops.
// Reset clears pointers and hold state and loads the settings defaults; no clearing pass.
module button_autorepeat_scanner #(
	parameter int QUEUE_SLOTS  = 8,
	parameter int BUTTON_COUNT = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bas_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [bas_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bas_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	bas_cmd_if.sink                          cmd,
	bas_evt_if.source                        evt
);

	localparam int EVENT_W = $clog2(BUTTON_COUNT + 1);
	localparam int HIDX_W  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int SW      = bas_pkg::SETTING_W;
	localparam int TW      = bas_pkg::STAMP_W;

	// settings
	logic [SW-1:0] delay_q, interval_q;
	logic          wr_en;
	bas_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = bas_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= bas_pkg::DELAY_RESET;
			interval_q <= bas_pkg::INTERVAL_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				bas_pkg::REG_DELAY:    delay_q    <= pwdata[SW-1:0];
				bas_pkg::REG_INTERVAL: interval_q <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bas_pkg::REG_DELAY:    prdata = {{(bas_pkg::APB_DATA_W-SW){1'b0}}, delay_q};
			bas_pkg::REG_INTERVAL: prdata = {{(bas_pkg::APB_DATA_W-SW){1'b0}}, interval_q};
			default:               prdata = '0;
		endcase
	end

	// input register
	logic                    valid_s1;
	bas_pkg::func_t          func_s1;
	logic [TW-1:0]           now_s1;
	logic [BUTTON_COUNT-1:0] low_s1, conf_s1;
	logic [EVENT_W-1:0]      code_s1;

	logic               out_valid_q;
	logic [EVENT_W-1:0] event_q;
	logic               dropped_q;
	logic               advance;

	assign advance   = valid_s1 && (!out_valid_q || evt.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			func_s1 <= bas_pkg::func_t'(cmd.func);
			now_s1  <= cmd.now_ms;
			low_s1  <= cmd.buttons_low;
			conf_s1 <= cmd.buttons_confirm;
			code_s1 <= cmd.event_code;
		end
	end

	// ring
	bas_pkg::ring_ctrl_t ring_ctrl;
	bas_pkg::ring_stat_t ring_stat;
	logic [EVENT_W-1:0]  head_data;
	logic                push_d, pop_d;

	assign ring_ctrl.push = advance && push_d;
	assign ring_ctrl.pop  = advance && pop_d;

	bas_inject_ring #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.EVENT_W     (EVENT_W)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ring_ctrl),
		.push_data (code_s1),
		.stat      (ring_stat),
		.head_data (head_data)
	);

	// hold state
	logic              held_valid_q, held_valid_d;
	logic [HIDX_W-1:0] held_idx_q, held_idx_d;
	logic [TW-1:0]     press_q, press_d;
	logic              rep_q, rep_d;
	logic [TW-1:0]     last_q, last_d;

	logic [BUTTON_COUNT-1:0] hit;
	logic                    scan_found;
	logic [HIDX_W-1:0]       scan_idx;
	logic [TW-1:0]           since_press, since_last;
	logic                    code_ok, rescan;
	logic [EVENT_W-1:0]      ev_d;
	logic                    drop_d;

	assign hit         = low_s1 & conf_s1;
	assign since_press = now_s1 - press_q;
	assign since_last  = now_s1 - last_q;
	assign code_ok     = (code_s1 != '0) && (code_s1 <= EVENT_W'(BUTTON_COUNT));

	always_comb begin
		scan_found = 1'b0;
		scan_idx   = '0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				scan_found = 1'b1;
				scan_idx   = HIDX_W'(i);
			end
		end
	end

	always_comb begin
		ev_d         = '0;
		drop_d       = 1'b0;
		push_d       = 1'b0;
		pop_d        = 1'b0;
		rescan       = 1'b0;
		held_valid_d = held_valid_q;
		held_idx_d   = held_idx_q;
		press_d      = press_q;
		rep_d        = rep_q;
		last_d       = last_q;
		if (func_s1 == bas_pkg::FUNC_INJECT) begin
			if (code_ok) begin
				if (ring_stat.full) begin
					drop_d = 1'b1;
				end else begin
					push_d = 1'b1;
				end
			end
		end else if (!ring_stat.empty) begin
			pop_d = 1'b1;
			ev_d  = head_data;
		end else begin
			rescan = 1'b1;
			if (held_valid_q) begin
				if (low_s1[held_idx_q]) begin
					rescan = 1'b0;
					if (!rep_q) begin
						if (since_press >= TW'(delay_q)) begin
							rep_d  = 1'b1;
							last_d = now_s1;
							ev_d   = EVENT_W'(held_idx_q) + EVENT_W'(1);
						end
					end else if (since_last >= TW'(interval_q)) begin
						last_d = now_s1;
						ev_d   = EVENT_W'(held_idx_q) + EVENT_W'(1);
					end
				end else begin
					held_valid_d = 1'b0;
					rep_d        = 1'b0;
				end
			end
			if (rescan && scan_found) begin
				held_valid_d = 1'b1;
				held_idx_d   = scan_idx;
				press_d      = now_s1;
				rep_d        = 1'b0;
				ev_d         = EVENT_W'(scan_idx) + EVENT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_idx_q   <= '0;
			press_q      <= '0;
			rep_q        <= 1'b0;
			last_q       <= '0;
		end else if (advance) begin
			held_valid_q <= held_valid_d;
			held_idx_q   <= held_idx_d;
			press_q      <= press_d;
			rep_q        <= rep_d;
			last_q       <= last_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= ev_d;
			dropped_q <= drop_d;
		end
	end

	assign evt.valid     = out_valid_q;
	assign evt.event_res = event_q;
	assign evt.dropped   = dropped_q;

endmodule

[sim/button_autorepeat_scanner_tb.sv]
// Testbench for the button auto-repeat scanner: directed table plus random polls and injections.
module button_autorepeat_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUTTONS = 6;
	localparam int DIR_ROWS = 25;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] EVENT_NONE = 3'd0;

	typedef struct packed {
		bas_pkg::func_t func;
		logic [31:0]    now_ms;
		logic [5:0]     low;
		logic [5:0]     confirm;
		logic [2:0]     code;
	} scan_cmd_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       dropped;
	} scan_result_t;

	typedef struct {
		bas_pkg::func_t func;
		logic [31:0]    now_ms;
		logic [5:0]     low;
		logic [5:0]     confirm;
		logic [2:0]     code;
		bit             typed;
		logic [2:0]     ev;
		logic           dr;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bas_pkg::APB_ADDR_W-1:0] paddr;
	logic [bas_pkg::APB_DATA_W-1:0] pwdata;
	logic [bas_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	bas_cmd_if #(.BUTTON_COUNT(BUTTONS), .EVENT_W(3)) cmd_ch ();
	bas_evt_if #(.EVENT_W(3)) evt_ch ();

	button_autorepeat_scanner #(
		.QUEUE_SLOTS(8),
		.BUTTON_COUNT(BUTTONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_ch),
		.evt(evt_ch)
	);

	// scanner state as predicted
	logic [2:0]          inj_ring [8];
	logic [2:0]          ring_head;
	logic [2:0]          ring_tail;
	logic                held_valid;
	logic [2:0]          held_idx;
	logic [31:0]         press_stamp;
	logic                repeating;
	logic [31:0]         last_repeat_stamp;
	logic [bas_pkg::SETTING_W-1:0] cfg_delay_ms;
	logic [bas_pkg::SETTING_W-1:0] cfg_interval_ms;

	scan_result_t pending_events[$];
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  phase_sent;
	logic [31:0]  ms_clock = 32'd0;
	bit           idle_on = 1'b1;
	bit           quiet_mode = 1'b0;
	int unsigned  rx_hold_left = 0;
	int unsigned  rx_stall_left = 0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{bas_pkg::FUNC_POLL,   32'd0,        6'h00, 6'h00, 3'd0, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd0, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'hFFFFFFFF, 6'h3F, 6'h3F, 3'd7, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd1, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd2, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd3, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd4, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd5, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd6, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd6, 1'b1, 3'd0, 1'b0},
		'{bas_pkg::FUNC_INJECT, 32'd0,        6'h00, 6'h00, 3'd3, 1'b1, 3'd0, 1'b1},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd1, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd2, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd3, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd4, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd5, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd6, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd10,       6'h3F, 6'h3F, 3'd0, 1'b1, 3'd6, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd100,      6'h3F, 6'h3E, 3'd0, 1'b0, 3'd0, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd1099,     6'h02, 6'h00, 3'd0, 1'b0, 3'd0, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd1100,     6'h02, 6'h00, 3'd0, 1'b0, 3'd0, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd1300,     6'h00, 6'h00, 3'd0, 1'b0, 3'd0, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'hFFFFFFFF, 6'h20, 6'h20, 3'd0, 1'b1, 3'd6, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd998,      6'h20, 6'h00, 3'd0, 1'b0, 3'd0, 1'b0},
		'{bas_pkg::FUNC_POLL,   32'd999,      6'h3F, 6'h3F, 3'd0, 1'b0, 3'd0, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("button_autorepeat_scanner_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic void reset_scanner_state();
		ring_head = '0;
		ring_tail = '0;
		held_valid = 1'b0;
		held_idx = '0;
		press_stamp = '0;
		repeating = 1'b0;
		last_repeat_stamp = '0;
		cfg_delay_ms = bas_pkg::DELAY_RESET;
		cfg_interval_ms = bas_pkg::INTERVAL_RESET;
	endfunction

	function automatic scan_result_t predict_event(scan_cmd_t c);
		scan_result_t r;
		r = '0;
		if (c.func == bas_pkg::FUNC_INJECT) begin
			if (c.code != EVENT_NONE && c.code <= BUTTONS) begin
				if (3'(ring_tail + 3'd1) == ring_head) begin
					r.dropped = 1'b1;
				end else begin
					inj_ring[ring_tail] = c.code;
					ring_tail = 3'(ring_tail + 3'd1);
				end
			end
			return r;
		end
		if (ring_head != ring_tail) begin
			r.event_res = inj_ring[ring_head];
			ring_head = 3'(ring_head + 3'd1);
			return r;
		end
		if (held_valid) begin
			if (c.low[held_idx]) begin
				if (!repeating) begin
					if (32'(c.now_ms - press_stamp) >= {16'h0, cfg_delay_ms}) begin
						repeating = 1'b1;
						last_repeat_stamp = c.now_ms;
						r.event_res = 3'(held_idx + 3'd1);
					end
				end else if (32'(c.now_ms - last_repeat_stamp) >= {16'h0, cfg_interval_ms}) begin
					last_repeat_stamp = c.now_ms;
					r.event_res = 3'(held_idx + 3'd1);
				end
				return r;
			end
			held_valid = 1'b0;
			repeating = 1'b0;
		end
		for (int i = 0; i < BUTTONS; i++) begin
			if (c.low[i] && c.confirm[i]) begin
				held_valid = 1'b1;
				held_idx = 3'(i);
				press_stamp = c.now_ms;
				repeating = 1'b0;
				r.event_res = 3'(i + 1);
				return r;
			end
		end
		return r;
	endfunction

	function automatic void check_event(logic [2:0] ev, logic dr);
		scan_result_t want;
		if (pending_events.size() == 0) begin
			$error("unexpected result: event_res %0d dropped %0d", ev, dr);
			fail_count++;
			return;
		end
		want = pending_events.pop_front();
		if (ev !== want.event_res) begin
			$error("event_res: expected %0d, actual %0d", want.event_res, ev);
			fail_count++;
		end
		if (dr !== want.dropped) begin
			$error("dropped: expected %0d, actual %0d", want.dropped, dr);
			fail_count++;
		end
	endfunction

	// result side: random stalls, one long hold-off on request
	initial begin
		bit rdy;
		evt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && evt_ch.valid && evt_ch.ready)
				check_event(evt_ch.event_res, evt_ch.dropped);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rdy = 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				rdy = 1'b0;
			end else if (!quiet_mode && idle_on && $urandom_range(0, 5) == 0) begin
				rx_stall_left = $urandom_range(1, 6) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			evt_ch.ready <= rdy;
		end
	end

	function automatic scan_cmd_t mk_poll(logic [31:0] now, logic [5:0] low, logic [5:0] conf);
		scan_cmd_t c;
		c.func = bas_pkg::FUNC_POLL;
		c.now_ms = now;
		c.low = low;
		c.confirm = conf;
		c.code = 3'($urandom);
		return c;
	endfunction

	function automatic scan_cmd_t mk_inject(logic [2:0] code);
		scan_cmd_t c;
		c.func = bas_pkg::FUNC_INJECT;
		c.now_ms = $urandom;
		c.low = 6'($urandom);
		c.confirm = 6'($urandom);
		c.code = code;
		return c;
	endfunction

	function automatic logic [31:0] time_step();
		int unsigned base;
		base = $urandom_range(0, 1) ? cfg_delay_ms : cfg_interval_ms;
		return $urandom_range(0, base + base / 4 + 2);
	endfunction

	task automatic send_cmd(scan_cmd_t c, bit typed = 1'b0, scan_result_t typed_res = '0);
		scan_result_t p;
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= c.func;
		cmd_ch.now_ms <= c.now_ms;
		cmd_ch.buttons_low <= c.low;
		cmd_ch.buttons_confirm <= c.confirm;
		cmd_ch.event_code <= c.code;
		do @(posedge clk); while (!cmd_ch.ready);
		p = predict_event(c);
		pending_events.push_back(typed ? typed_res : p);
		phase_sent++;
		if (!quiet_mode && idle_on && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic apb_access(bas_pkg::reg_idx_t r, bit wr, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_register(bas_pkg::reg_idx_t r, logic [bas_pkg::SETTING_W-1:0] v);
		logic [31:0] rd;
		apb_access(r, 1'b1, {16'h0, v}, rd);
		if (r == bas_pkg::REG_DELAY)
			cfg_delay_ms = v;
		else
			cfg_interval_ms = v;
		apb_access(r, 1'b0, '0, rd);
		if (rd !== {16'h0, v}) begin
			$error("prdata: expected %0d, actual %0d", {16'h0, v}, rd);
			fail_count++;
		end
	endtask

	task automatic hold_session();
		int polls;
		logic [5:0] pick;
		logic [5:0] below;
		pick = 6'(1 << $urandom_range(0, BUTTONS - 1));
		below = pick - 6'd1;
		polls = $urandom_range(2, 14);
		ms_clock += $urandom_range(0, 50);
		send_cmd(mk_poll(ms_clock, 6'($urandom) | pick, (6'($urandom) & ~below) | pick));
		for (int k = 0; k < polls; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_cmd(mk_inject(3'($urandom_range(1, BUTTONS))));
			end else begin
				ms_clock += time_step();
				send_cmd(mk_poll(ms_clock, 6'($urandom) | pick, 6'($urandom)));
			end
		end
		if ($urandom_range(0, 2) != 0) begin
			ms_clock += $urandom_range(0, 200);
			send_cmd(mk_poll(ms_clock, 6'($urandom) & ~pick, 6'($urandom)));
		end
	endtask

	task automatic inject_session();
		int n;
		n = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_cmd(mk_inject(3'($urandom)));
			else
				send_cmd(mk_inject(3'($urandom_range(1, BUTTONS))));
		end
		for (int k = $urandom_range(0, n + 1); k > 0; k--) begin
			ms_clock += $urandom_range(0, 20);
			send_cmd(mk_poll(ms_clock, 6'($urandom), 6'($urandom)));
		end
	endtask

	task automatic noise_session();
		scan_cmd_t c;
		for (int k = $urandom_range(1, 4); k > 0; k--) begin
			c = mk_poll($urandom, 6'($urandom), 6'($urandom));
			if ($urandom_range(0, 1))
				c.func = bas_pkg::FUNC_INJECT;
			send_cmd(c);
			if ($urandom_range(0, 3) == 0)
				ms_clock = c.now_ms;
			else if ($urandom_range(0, 7) == 0)
				ms_clock = 32'hFFFFFFFF - $urandom_range(0, 2000);
		end
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	initial begin
		scan_cmd_t c;
		scan_result_t tr;
		int unsigned kind;
		logic [bas_pkg::SETTING_W-1:0] dly;
		logic [bas_pkg::SETTING_W-1:0] ivl;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= bas_pkg::FUNC_POLL;
		cmd_ch.now_ms <= '0;
		cmd_ch.buttons_low <= '0;
		cmd_ch.buttons_confirm <= '0;
		cmd_ch.event_code <= EVENT_NONE;
		reset_scanner_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			c.func = directed_rows[i].func;
			c.now_ms = directed_rows[i].now_ms;
			c.low = directed_rows[i].low;
			c.confirm = directed_rows[i].confirm;
			c.code = directed_rows[i].code;
			tr.event_res = directed_rows[i].ev;
			tr.dropped = directed_rows[i].dr;
			send_cmd(c, directed_rows[i].typed, tr);
		end
		cmd_ch.valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			unique case (p)
				0: begin dly = bas_pkg::DELAY_RESET; ivl = bas_pkg::INTERVAL_RESET; end
				1: begin dly = '0; ivl = '0; end
				2: begin dly = 16'hFFFF; ivl = 16'hFFFF; end
				3: begin dly = '0; ivl = 16'hFFFF; end
				4: begin dly = 16'hFFFF; ivl = '0; end
				5: begin dly = 16'($urandom); ivl = 16'($urandom); end
				default: begin
					dly = 16'($urandom_range(0, 400));
					ivl = 16'($urandom_range(0, 120));
				end
			endcase
			set_register(bas_pkg::REG_DELAY, dly);
			set_register(bas_pkg::REG_INTERVAL, ivl);
			if (p == 1)
				rx_hold_left = 200;
			quiet_mode = (p == PHASES - 1);
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				idle_on = ($urandom_range(0, 3) != 0);
				kind = $urandom_range(0, 9);
				if (kind < 6)
					hold_session();
				else if (kind < 8)
					inject_session();
				else
					noise_session();
			end
			cmd_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("button_autorepeat_scanner_tb: PASS");
		else
			$display("button_autorepeat_scanner_tb: FAIL");
		$finish;
	end

endmodule
